@@ hdl/modexp_pkg.sv @@
package modexp_pkg;

  // Field widths of the stream payload.
  localparam int unsigned BASE_W = 32;
  localparam int unsigned EXPONENT_W = 32;
  localparam int unsigned RES_W = 30;

  // Default number of exponent bits that are used.
  localparam int unsigned EXP_BITS_DEF = 32;

  // The prime modulus, 119 * 2^23 + 1.
  localparam logic [RES_W-1:0] PRIME_MOD = 30'd998244353;

  // Fermat inverse exponent, prime minus two.
  localparam logic [RES_W-1:0] INV_EXP = PRIME_MOD - 30'd2;

  // Twice the prime, used in the first correction of the reduction.
  localparam logic [31:0] TWO_PRIME = {1'b0, PRIME_MOD, 1'b0};

  // Barrett factor floor(2^60 / prime); it fits in 31 bits.
  localparam logic [63:0] MU_FULL = 64'h1000_0000_0000_0000 / {34'd0, PRIME_MOD};
  localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

  // Register stages of the modular multiplier.
  localparam int unsigned MUL_LAT = 6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take a new item into the working registers
    logic reduce;     // subtract the prime once from the squared base
    logic mul_start;  // launch both modular products
    logic update;     // take the products and shift the exponent
    logic out_load;   // copy the accumulator into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sq_ge_p;    // squared base not yet below the prime
    logic exp_zero;   // no exponent bits left to process
    logic mul_done;   // both modular products are ready
  } sts_t;

endpackage

@@ hdl/modexp_mulmod.sv @@
module modexp_mulmod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [modexp_pkg::RES_W-1:0] a_i,
  input  logic [modexp_pkg::RES_W-1:0] b_i,
  output logic                       done_o,
  output logic [modexp_pkg::RES_W-1:0] prod_o
);
  import modexp_pkg::*;

  logic [MUL_LAT-1:0] vld_q;
  logic [59:0]        p1_q;
  logic [61:0]        qm;
  logic [29:0]        q2_q;
  logic [31:0]        l2_q;
  logic [31:0]        qp;
  logic [31:0]        qp3_q;
  logic [31:0]        l3_q;
  logic [31:0]        r4_q;
  logic [31:0]        r5_q;
  logic [RES_W-1:0]   r6_q;

  // Quotient estimate and its product with the prime.
  assign qm = {31'd0, p1_q[59:29]} * {31'd0, BARRETT_MU};
  assign qp = {2'd0, q2_q} * {2'd0, PRIME_MOD};

  // Valid marker that travels beside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[MUL_LAT-2:0], start_i};
    end
  end

  // Barrett reduction: full product, quotient, remainder, two corrections.
  // The remainder before correction lies below three times the prime.
  always_ff @(posedge clk_i) begin
    p1_q  <= {30'd0, a_i} * {30'd0, b_i};
    q2_q  <= qm[60:31];
    l2_q  <= p1_q[31:0];
    qp3_q <= qp;
    l3_q  <= l2_q;
    r4_q  <= l3_q - qp3_q;
    r5_q  <= (r4_q >= TWO_PRIME) ? r4_q - TWO_PRIME : r4_q;
    r6_q  <= (r5_q >= {2'd0, PRIME_MOD}) ? RES_W'(r5_q - {2'd0, PRIME_MOD}) : r5_q[RES_W-1:0];
  end

  assign done_o = vld_q[MUL_LAT-1];
  assign prod_o = r6_q;

endmodule

@@ hdl/modexp_datapath.sv @@
module modexp_datapath #(
  parameter int unsigned EXP_BITS = modexp_pkg::EXP_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  modexp_pkg::cmd_t                  cmd_i,
  input  logic                              action_i,
  input  logic [modexp_pkg::BASE_W-1:0]     base_i,
  input  logic [modexp_pkg::EXPONENT_W-1:0] exponent_i,
  output modexp_pkg::sts_t                  sts_o,
  output logic [modexp_pkg::RES_W-1:0]      result_o
);
  import modexp_pkg::*;

  logic [EXP_BITS-1:0] exp_q, exp_d;
  logic [BASE_W-1:0]   sq_q, sq_d;
  logic [RES_W-1:0]    acc_q, acc_d;
  logic [RES_W-1:0]    res_q, res_d;
  logic [63:0]         exp_ext;
  logic [63:0]         inv_ext;
  logic                done_a;
  logic                done_b;
  logic [RES_W-1:0]    prod_a;
  logic [RES_W-1:0]    prod_b;

  assign exp_ext = {{(64-EXPONENT_W){1'b0}}, exponent_i};
  assign inv_ext = {{(64-RES_W){1'b0}}, INV_EXP};

  // Accumulator times square, and square times square, run side by side.
  modexp_mulmod u_mul_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (acc_q),
    .b_i     (sq_q[RES_W-1:0]),
    .done_o  (done_a),
    .prod_o  (prod_a)
  );

  modexp_mulmod u_mul_sq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (sq_q[RES_W-1:0]),
    .b_i     (sq_q[RES_W-1:0]),
    .done_o  (done_b),
    .prod_o  (prod_b)
  );

  // Next values of the working registers.
  always_comb begin
    exp_d = exp_q;
    sq_d  = sq_q;
    acc_d = acc_q;
    res_d = res_q;
    if (cmd_i.load) begin
      exp_d = action_i ? inv_ext[EXP_BITS-1:0] : exp_ext[EXP_BITS-1:0];
      sq_d  = base_i;
      acc_d = RES_W'(1);
    end
    if (cmd_i.reduce) begin
      sq_d = sq_q - {2'd0, PRIME_MOD};
    end
    if (cmd_i.update) begin
      if (exp_q[0]) begin
        acc_d = prod_a;
      end
      sq_d  = {2'd0, prod_b};
      exp_d = exp_q >> 1;
    end
    if (cmd_i.out_load) begin
      res_d = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q <= exp_d;
    sq_q  <= sq_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  // Status back to the controller.
  assign sts_o.sq_ge_p  = (sq_q >= {2'd0, PRIME_MOD});
  assign sts_o.exp_zero = (exp_q == '0);
  assign sts_o.mul_done = done_a & done_b;

  assign result_o = res_q;

endmodule

@@ hdl/modexp_ctrl.sv @@
module modexp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  input  modexp_pkg::sts_t sts_i,
  output modexp_pkg::cmd_t cmd_o
);
  import modexp_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_WAIT   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_vld_q, out_vld_d;

  // Sequencing of one item: reduce the base, then one step per exponent bit.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (sts_i.sq_ge_p) begin
          cmd_o.reduce = 1'b1;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.exp_zero) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.mul_start = 1'b1;
          state_d         = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.update = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (!out_vld_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register valid: set on a new result, cleared when it is taken.
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (m_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = out_vld_q;

endmodule

@@ hdl/modular_exponentiation.sv @@
// Modular exponentiation modulo the prime 998244353.
// Input stream: s_axis_tdata carries base (bits 31:0) and exponent (bits 63:32);
// s_axis_tuser selects the action: 0 raises base to exponent, 1 returns the
// modular inverse of base (exponent ignored; zero maps to zero).
// Output stream: m_axis_tdata carries the 30-bit result in bits 29:0.
// One result leaves for every item taken; items are handled one at a time.
// Each exponent bit up to the highest set one (30 bits for an inverse) takes one
// pass through the six-stage Barrett multipliers and then an update; before
// that, the base is brought below the prime by at most 4 subtractions of it.
// s_axis_tready is high only while the block is idle. The finished result sits
// in an output register, so a new item is taken while it waits; if the
// receiver still stalls when the next result is ready, the block holds it and
// waits. Reset clears the controller and the output valid; no state is kept
// between items.
module modular_exponentiation #(
  parameter int unsigned EXP_BITS = modexp_pkg::EXP_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // base [31:0], exponent [63:32]
  input  logic [0:0]  s_axis_tuser,   // action [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // result [29:0], zero [31:30]
);
  import modexp_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [RES_W-1:0] result;

  modexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  modexp_datapath #(
    .EXP_BITS (EXP_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .action_i   (s_axis_tuser[0]),
    .base_i     (s_axis_tdata[BASE_W-1:0]),
    .exponent_i (s_axis_tdata[BASE_W+EXPONENT_W-1:BASE_W]),
    .sts_o      (sts),
    .result_o   (result)
  );

  assign m_axis_tdata = {2'b00, result};

  // Once an item is taken, no other is taken until its work is done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

  // Every result offered is fully reduced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata < {2'b00, PRIME_MOD}))
    else $error("result not below the prime");

  // Multiplier results only arrive while an item is in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.mul_done |-> !s_axis_tready)
    else $error("multiplier finished while idle");

  // A result is loaded only when the output register is free or being emptied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

endmodule
